[rtl/svcc_pkg.sv]
// ============================================================================
// Segment view clip classifier package
// Shared constants, register codes and the structs that carry clip state
// from one pipeline stage to the next.
// ============================================================================
package svcc_pkg;

  // Default number of fraction bits in a coordinate.
  localparam int CoordFracBits = 16;

  // Configuration port address width (six 32-bit registers).
  localparam int ApbAddrW = 5;

  // Width of the widened view bounds and of the clip distances.
  localparam int BndW = 36;

  // Register reset values.
  localparam logic signed [31:0] ViewLeftRst   = -32'sd131072;
  localparam logic signed [31:0] ViewRightRst  = 32'sd131072;
  localparam logic signed [31:0] ViewBottomRst = -32'sd131072;
  localparam logic signed [31:0] ViewTopRst    = 32'sd131072;
  localparam logic [15:0]        ScreenWRst    = 16'd800;
  localparam logic [15:0]        ScreenHRst    = 16'd600;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_VIEW_LEFT     = 3'd0,
    REG_VIEW_RIGHT    = 3'd1,
    REG_VIEW_BOTTOM   = 3'd2,
    REG_VIEW_TOP      = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } cfg_reg_t;

  // Sequencer that recomputes the pixel margins after a register write.
  typedef enum logic [1:0] {
    MG_IDLE,
    MG_LOAD,
    MG_DIV,
    MG_BOUNDS
  } mg_state_t;

  // A parameter value kept as an exact fraction.
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
  } ratio_t;

  // Clip state handed from one boundary to the next.
  typedef struct packed {
    logic   ok;
    ratio_t entry;
    ratio_t exitv;
  } clip_state_t;

  // Segment geometry carried along the clip stages.
  typedef struct packed {
    logic signed [32:0]     dx;
    logic signed [32:0]     dy;
    logic [3:0][BndW-1:0]   q;
  } geom_t;

  // One boundary after the cross products are formed.
  typedef struct packed {
    logic        ok;
    logic        normal;
    logic        fixed_ok;
    logic        pneg;
    ratio_t      entry;
    ratio_t      exitv;
    logic [31:0] un;
    logic [31:0] ud;
    logic [63:0] m_ue;
    logic [63:0] m_eu;
    logic [63:0] m_un;
    logic [63:0] m_nu;
  } edge_t;

endpackage

[rtl/segment_view_clip_classifier.sv]
// ============================================================================
// Segment view clip classifier
// Parametric clip of a segment against the widened view and a subpixel
// length test, one segment per clock while busy is low.
// ============================================================================
// A segment is taken on any clock edge where start is high and busy is low,
// one word per cycle with no gaps needed. Its flags appear on visible and
// subpixel with done high for one cycle, after the clip stages and the
// pipelined pixel-length divider, one quotient bit per stage. The output
// cannot be held off, so the receiver must take every word. After reset and
// after every register write, busy stays high while a sequential divider on
// each axis recomputes the one-pixel margins (32 steps plus load and bounds
// update); registers should be written through the APB port only while no
// segment is in flight.
module segment_view_clip_classifier
  import svcc_pkg::*;
#(
  parameter int COORD_FRAC_BITS = CoordFracBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ApbAddrW-1:0]       paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        x_start,
  input  logic signed [31:0]        y_start,
  input  logic signed [31:0]        x_end,
  input  logic signed [31:0]        y_end,
  output logic                      done,
  output logic                      visible,
  output logic                      subpixel
);

  localparam int F   = COORD_FRAC_BITS;
  localparam int VD  = F - 5;
  localparam int LAT = F + 5;
  localparam logic [2*F:0] SubLimit = (2*F+1)'(9) << (2*F - 4);
  localparam logic [F-1:0] PxMax    = F'(3) << (F - 2);

  // Configuration registers.
  logic signed [31:0] view_left, view_right, view_bottom, view_top;
  logic [15:0]        screen_width, screen_height;
  logic               cfg_wr;
  cfg_reg_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      view_left     <= ViewLeftRst;
      view_right    <= ViewRightRst;
      view_bottom   <= ViewBottomRst;
      view_top      <= ViewTopRst;
      screen_width  <= ScreenWRst;
      screen_height <= ScreenHRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VIEW_LEFT:     view_left     <= pwdata;
        REG_VIEW_RIGHT:    view_right    <= pwdata;
        REG_VIEW_BOTTOM:   view_bottom   <= pwdata;
        REG_VIEW_TOP:      view_top      <= pwdata;
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[15:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      REG_VIEW_LEFT:     prdata = view_left;
      REG_VIEW_RIGHT:    prdata = view_right;
      REG_VIEW_BOTTOM:   prdata = view_bottom;
      REG_VIEW_TOP:      prdata = view_top;
      REG_SCREEN_WIDTH:  prdata = {16'd0, screen_width};
      REG_SCREEN_HEIGHT: prdata = {16'd0, screen_height};
      default:           prdata = 32'd0;
    endcase
  end

  // View extents clamped to at least one LSB, screen sizes to at least one.
  logic signed [32:0] vw_diff, vh_diff;
  logic [31:0]        vw_calc, vh_calc;

  assign vw_diff = 33'(view_right) - 33'(view_left);
  assign vh_diff = 33'(view_top) - 33'(view_bottom);
  assign vw_calc = (vw_diff < 33'sd1) ? 32'd1 : vw_diff[31:0];
  assign vh_calc = (vh_diff < 33'sd1) ? 32'd1 : vh_diff[31:0];

  // Margin sequencer: one restoring division step per cycle on both axes.
  mg_state_t   mg_state, mg_state_next;
  logic [4:0]  mg_cnt;
  logic [31:0] vw_r, vh_r, mq_x, mq_y;
  logic [15:0] sw_r, sh_r, mr_x, mr_y;
  logic [16:0] rr_x, rr_y;
  logic        ge_x, ge_y;
  logic signed [BndW-1:0] lo_x, hi_x, lo_y, hi_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mg_state <= MG_LOAD;
    end else begin
      mg_state <= mg_state_next;
    end
  end

  always_comb begin
    mg_state_next = mg_state;
    if (cfg_wr) begin
      mg_state_next = MG_LOAD;
    end else begin
      unique case (mg_state)
        MG_IDLE:   mg_state_next = MG_IDLE;
        MG_LOAD:   mg_state_next = MG_DIV;
        MG_DIV:    mg_state_next = (mg_cnt == 5'd31) ? MG_BOUNDS : MG_DIV;
        MG_BOUNDS: mg_state_next = MG_IDLE;
        default:   mg_state_next = MG_LOAD;
      endcase
    end
  end

  assign busy = (mg_state != MG_IDLE);

  assign rr_x = {mr_x, mq_x[31]};
  assign rr_y = {mr_y, mq_y[31]};
  assign ge_x = (rr_x >= {1'b0, sw_r});
  assign ge_y = (rr_y >= {1'b0, sh_r});

  always_ff @(posedge clk) begin
    unique case (mg_state)
      MG_LOAD: begin
        vw_r   <= vw_calc;
        vh_r   <= vh_calc;
        sw_r   <= (screen_width == 16'd0) ? 16'd1 : screen_width;
        sh_r   <= (screen_height == 16'd0) ? 16'd1 : screen_height;
        mq_x   <= vw_calc;
        mq_y   <= vh_calc;
        mr_x   <= 16'd0;
        mr_y   <= 16'd0;
        mg_cnt <= 5'd0;
      end
      MG_DIV: begin
        mq_x   <= {mq_x[30:0], ge_x};
        mq_y   <= {mq_y[30:0], ge_y};
        mr_x   <= ge_x ? 16'(rr_x - {1'b0, sw_r}) : rr_x[15:0];
        mr_y   <= ge_y ? 16'(rr_y - {1'b0, sh_r}) : rr_y[15:0];
        mg_cnt <= mg_cnt + 5'd1;
      end
      MG_BOUNDS: begin
        lo_x <= BndW'(view_left)   - $signed({4'd0, mq_x});
        hi_x <= BndW'(view_right)  + $signed({4'd0, mq_x});
        lo_y <= BndW'(view_bottom) - $signed({4'd0, mq_y});
        hi_y <= BndW'(view_top)    + $signed({4'd0, mq_y});
      end
      default: ;
    endcase
  end

  // Stage 1: deltas and the four boundary distances.
  logic  in_acc, v1;
  geom_t geo [0:6];

  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    geo[0].dx   <= 33'(x_end) - 33'(x_start);
    geo[0].dy   <= 33'(y_end) - 33'(y_start);
    geo[0].q[0] <= BndW'(x_start) - lo_x;
    geo[0].q[1] <= hi_x - BndW'(x_start);
    geo[0].q[2] <= BndW'(y_start) - lo_y;
    geo[0].q[3] <= hi_y - BndW'(y_start);
  end

  // Geometry delay line alongside the clip stages.
  for (genvar j = 1; j <= 6; j++) begin : g_geo
    always_ff @(posedge clk) begin
      geo[j] <= geo[j-1];
    end
  end

  // Clip: each boundary takes a product stage and a compare stage.
  clip_state_t cs [0:4];
  edge_t       ea [0:3];

  assign cs[0] = {1'b1, 32'd0, 32'd1, 32'd1, 32'd1};

  for (genvar k = 0; k < 4; k++) begin : g_edge
    logic signed [BndW-1:0] p, q, n, d;

    // Direction and distance with the sign folded so the ratio is n / d.
    always_comb begin
      p = (k < 2) ? BndW'(geo[2*k].dx) : BndW'(geo[2*k].dy);
      if (k % 2 == 0) begin
        p = -p;
      end
      q = $signed(geo[2*k].q[k]);
      n = p[BndW-1] ? -q : q;
      d = p[BndW-1] ? -p : p;
    end

    always_ff @(posedge clk) begin
      ea[k].ok     <= cs[k].ok;
      ea[k].normal <= (p != '0) && !n[BndW-1] && !(n > d);
      if (p == '0) begin
        ea[k].fixed_ok <= !q[BndW-1];
      end else if (n[BndW-1]) begin
        ea[k].fixed_ok <= p[BndW-1];
      end else begin
        ea[k].fixed_ok <= !p[BndW-1];
      end
      ea[k].pneg  <= p[BndW-1];
      ea[k].entry <= cs[k].entry;
      ea[k].exitv <= cs[k].exitv;
      ea[k].un    <= n[31:0];
      ea[k].ud    <= d[31:0];
      ea[k].m_ue  <= 64'(n[31:0]) * 64'(cs[k].exitv.den);
      ea[k].m_eu  <= 64'(cs[k].exitv.num) * 64'(d[31:0]);
      ea[k].m_un  <= 64'(n[31:0]) * 64'(cs[k].entry.den);
      ea[k].m_nu  <= 64'(cs[k].entry.num) * 64'(d[31:0]);
    end

    // Compare the ratio against entry and exit and narrow the interval.
    always_ff @(posedge clk) begin
      if (ea[k].normal && ea[k].pneg && (ea[k].m_un > ea[k].m_nu)) begin
        cs[k+1].entry <= {ea[k].un, ea[k].ud};
      end else begin
        cs[k+1].entry <= ea[k].entry;
      end
      if (ea[k].normal && !ea[k].pneg && (ea[k].m_ue < ea[k].m_eu)) begin
        cs[k+1].exitv <= {ea[k].un, ea[k].ud};
      end else begin
        cs[k+1].exitv <= ea[k].exitv;
      end
      if (!ea[k].ok) begin
        cs[k+1].ok <= 1'b0;
      end else if (!ea[k].normal) begin
        cs[k+1].ok <= ea[k].fixed_ok;
      end else if (ea[k].pneg) begin
        cs[k+1].ok <= !(ea[k].m_ue > ea[k].m_eu);
      end else begin
        cs[k+1].ok <= !(ea[k].m_un < ea[k].m_nu);
      end
    end
  end

  // Visible flag waits for the longer subpixel path.
  logic vis_dly [0:VD];

  assign vis_dly[0] = cs[4].ok;

  for (genvar j = 1; j <= VD; j++) begin : g_vis
    always_ff @(posedge clk) begin
      vis_dly[j] <= vis_dly[j-1];
    end
  end

  // Subpixel: scale the deltas to pixels.
  logic        vm, vg;
  logic [31:0] absdx, absdy;
  logic [47:0] am, bm;

  assign absdx = geo[0].dx[32] ? 32'(-geo[0].dx) : geo[0].dx[31:0];
  assign absdy = geo[0].dy[32] ? 32'(-geo[0].dy) : geo[0].dy[31:0];

  always_ff @(posedge clk) begin
    am <= 48'(absdx) * 48'(sw_r);
    bm <= 48'(absdy) * 48'(sh_r);
  end

  // Reject lengths that are clearly over 0.75 pixel.
  logic          dv  [0:F];
  logic          dtb [0:F];
  logic [31:0]   drx [0:F];
  logic [31:0]   dry [0:F];
  logic [F-1:0]  dqx [0:F];
  logic [F-1:0]  dqy [0:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
      vg <= 1'b0;
    end else begin
      vm <= v1;
      vg <= vm;
    end
  end

  always_ff @(posedge clk) begin
    dtb[0] <= ({am, 2'b00} > ((50'(vw_r) << 1) + 50'(vw_r))) ||
              ({bm, 2'b00} > ((50'(vh_r) << 1) + 50'(vh_r)));
    drx[0] <= am[31:0];
    dry[0] <= bm[31:0];
    dqx[0] <= '0;
    dqy[0] <= '0;
  end

  assign dv[0] = vg;

  // Pixel length: one quotient bit per stage.
  for (genvar j = 1; j <= F; j++) begin : g_div
    logic [32:0] r2x, r2y;
    logic        gx, gy;

    assign r2x = {drx[j-1], 1'b0};
    assign r2y = {dry[j-1], 1'b0};
    assign gx  = (r2x >= {1'b0, vw_r});
    assign gy  = (r2y >= {1'b0, vh_r});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else begin
        dv[j] <= dv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      dtb[j] <= dtb[j-1];
      drx[j] <= gx ? 32'(r2x - {1'b0, vw_r}) : r2x[31:0];
      dry[j] <= gy ? 32'(r2y - {1'b0, vh_r}) : r2y[31:0];
      dqx[j] <= {dqx[j-1][F-2:0], gx};
      dqy[j] <= {dqy[j-1][F-2:0], gy};
    end
  end

  // Squares, then the sum against 0.5625.
  logic           vs, tbs;
  logic [2*F-1:0] sqx, sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs   <= 1'b0;
      done <= 1'b0;
    end else begin
      vs   <= dv[F];
      done <= vs;
    end
  end

  always_ff @(posedge clk) begin
    sqx      <= (2*F)'(dqx[F]) * (2*F)'(dqx[F]);
    sqy      <= (2*F)'(dqy[F]) * (2*F)'(dqy[F]);
    tbs      <= dtb[F];
    subpixel <= !tbs && (({1'b0, sqx} + {1'b0, sqy}) <= SubLimit);
    visible  <= vis_dly[VD];
  end

  // Every accepted segment gives exactly one word after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##LAT done)
    else $error("result word missing after fixed latency");

  // A register write holds off new segments while the margins are redone.
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy)
    else $error("block not busy after register write");

  // A length that passed the coarse test stays below 0.75 pixel in the divider.
  a_px_range: assert property (@(posedge clk) disable iff (rst)
    (dv[F] && !dtb[F]) |-> (dqx[F] <= PxMax && dqy[F] <= PxMax))
    else $error("pixel length out of range after coarse test");

endmodule

[tb/tb_segment_view_clip_classifier.sv]
// ============================================================================
// Segment view clip classifier testbench
// Drives segments through the command port and checks each visible and
// subpixel flag pair against an exact integer prediction of the clip and
// the pixel-length test, across several view and screen settings.
// ============================================================================
module tb_segment_view_clip_classifier;
  import svcc_pkg::*;

  localparam int FracBits = CoordFracBits;
  localparam int Latency = FracBits + 4;
  localparam int WatchLimit = 2000;

  // Flag pair expected for one segment.
  typedef struct packed {
    logic visible;
    logic subpixel;
  } flags_t;

  // Scoreboard holding the flag pairs still owed by the block.
  class flag_scoreboard;
    flags_t pending[$];
    int errors;
    int checked;

    function void note_segment(flags_t f);
      pending.push_back(f);
    endfunction

    function void check_word(logic vis, logic sub);
      flags_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual vis=%0b sub=%0b",
                 $time, vis, sub);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (vis !== e.visible) begin
        $display("%0t: visible mismatch, expected %0b, actual %0b", $time, e.visible, vis);
        errors++;
      end
      if (sub !== e.subpixel) begin
        $display("%0t: subpixel mismatch, expected %0b, actual %0b", $time, e.subpixel, sub);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic start, busy, done, visible, subpixel;
  logic signed [31:0] x_start, y_start, x_end, y_end;

  // Local copy of the configuration.
  longint v_left, v_right, v_bottom, v_top;
  longint s_width, s_height;

  flag_scoreboard sb;
  int idle_cycles;
  int accepted;

  segment_view_clip_classifier DUT (.*);

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each output word and count cycles with no progress.
  always @(posedge clk) begin
    if (!rst && done) sb.check_word(visible, subpixel);
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One boundary of the parametric clip; ratios are kept as exact fractions.
  // Cross products reach 64 bits, so they are formed unsigned.
  function automatic bit clip_boundary(longint p, longint q, ref longint en_n, en_d,
                                       ref longint ex_n, ex_d);
    longint n, d;
    longint unsigned un, ud;
    if (p == 0) return q >= 0;
    if (p < 0) begin
      n = -q;
      d = -p;
    end else begin
      n = q;
      d = p;
    end
    if (n < 0) return p < 0;
    if (n > d) return p > 0;
    un = n;
    ud = d;
    if (p < 0) begin
      if (un * ex_d > ex_n * ud) return 0;
      if (un * en_d > en_n * ud) begin
        en_n = n;
        en_d = d;
      end
    end else begin
      if (un * en_d < en_n * ud) return 0;
      if (un * ex_d < ex_n * ud) begin
        ex_n = n;
        ex_d = d;
      end
    end
    return 1;
  endfunction

  // Predict the flag pair for one segment.
  function automatic flags_t classify_segment(longint x1, y1, x2, y2);
    flags_t f;
    longint vw, vh, sw, sh, mx, my, dx, dy, en_n, en_d, ex_n, ex_d;
    logic [127:0] a, b, px, py, lim;
    vw = v_right - v_left;
    vh = v_top - v_bottom;
    sw = (s_width == 0) ? 1 : s_width;
    sh = (s_height == 0) ? 1 : s_height;
    if (vw < 1) vw = 1;
    if (vh < 1) vh = 1;
    mx = vw / sw;
    my = vh / sh;
    dx = x2 - x1;
    dy = y2 - y1;
    en_n = 0; en_d = 1; ex_n = 1; ex_d = 1;
    f.visible = clip_boundary(-dx, x1 - (v_left - mx), en_n, en_d, ex_n, ex_d) &&
                clip_boundary(dx, v_right + mx - x1, en_n, en_d, ex_n, ex_d) &&
                clip_boundary(-dy, y1 - (v_bottom - my), en_n, en_d, ex_n, ex_d) &&
                clip_boundary(dy, v_top + my - y1, en_n, en_d, ex_n, ex_d);
    a = 128'((dx < 0) ? -dx : dx) * 128'(sw);
    b = 128'((dy < 0) ? -dy : dy) * 128'(sh);
    if (4 * a > 3 * 128'(vw) || 4 * b > 3 * 128'(vh)) begin
      f.subpixel = 1'b0;
    end else begin
      px = (a << FracBits) / 128'(vw);
      py = (b << FracBits) / 128'(vh);
      lim = 128'(9) << (2 * FracBits - 4);
      f.subpixel = (px * px + py * py) <= lim;
    end
    return f;
  endfunction

  // Write one register through the configuration port and update the local copy.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_VIEW_LEFT:     v_left = longint'(signed'(value));
      REG_VIEW_RIGHT:    v_right = longint'(signed'(value));
      REG_VIEW_BOTTOM:   v_bottom = longint'(signed'(value));
      REG_VIEW_TOP:      v_top = longint'(signed'(value));
      REG_SCREEN_WIDTH:  s_width = value[15:0];
      REG_SCREEN_HEIGHT: s_height = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Wait for every owed word plus the pipeline depth.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // Load a full view and screen setting.
  task automatic set_view(logic [31:0] l, r, bt, tp, logic [15:0] w, h);
    drain();
    write_reg(REG_VIEW_LEFT, l);
    write_reg(REG_VIEW_RIGHT, r);
    write_reg(REG_VIEW_BOTTOM, bt);
    write_reg(REG_VIEW_TOP, tp);
    write_reg(REG_SCREEN_WIDTH, {16'd0, w});
    write_reg(REG_SCREEN_HEIGHT, {16'd0, h});
  endtask

  // Send one segment word, with a random lead-in gap when gaps is set.
  task automatic send_segment(logic [31:0] x1, y1, x2, y2, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    x_start <= x1;
    y_start <= y1;
    x_end <= x2;
    y_end <= y2;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_segment(classify_segment(signed'(x1), signed'(y1), signed'(x2), signed'(y2)));
    accepted++;
  endtask

  // Random coordinate: mostly near the view, sometimes anywhere.
  function automatic logic [31:0] rand_coord(longint lo, hi);
    longint span, c;
    if ($urandom_range(0, 4) == 0) return $urandom;
    span = hi - lo + 8;
    if (span > 64'h7fffffff) return $urandom;
    c = lo - 4 + longint'($urandom_range(0, 32'(span)));
    if (c > 64'sh7fffffff || c < -64'sh80000000) return $urandom;
    return c[31:0];
  endfunction

  // A burst of random segments under the current setting.
  task automatic random_phase(int count);
    logic [31:0] x1, y1, x2, y2;
    bit gaps;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps = $urandom_range(0, 2) != 0;
      x1 = rand_coord(v_left, v_right);
      y1 = rand_coord(v_bottom, v_top);
      case ($urandom_range(0, 3))
        0: begin
          // Short segment, often below a pixel.
          x2 = x1 + 32'(signed'($urandom_range(0, 512)) - 256);
          y2 = y1 + 32'(signed'($urandom_range(0, 512)) - 256);
        end
        1: begin
          // Parallel to one axis.
          x2 = $urandom_range(0, 1) ? x1 : rand_coord(v_left, v_right);
          y2 = (x2 == x1) ? rand_coord(v_bottom, v_top) : y1;
        end
        default: begin
          x2 = rand_coord(v_left, v_right);
          y2 = rand_coord(v_bottom, v_top);
        end
      endcase
      send_segment(x1, y1, x2, y2, gaps);
    end
    start <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    clk = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0;
    x_start = '0; y_start = '0; x_end = '0; y_end = '0;
    idle_cycles = 0;
    accepted = 0;
    v_left = -131072; v_right = 131072; v_bottom = -131072; v_top = 131072;
    s_width = 800; s_height = 600;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed segments at reset settings: extremes, points, parallels.
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_segment(32'd0, 32'd0, 32'd0, 32'd0, 0);
    send_segment(32'h0003_0000, 32'd0, 32'h0003_0000, 32'd0, 0);
    send_segment(32'hfffd_f000, 32'h0000_1000, 32'hfffd_f000, 32'h0001_0000, 0);
    send_segment(32'h0002_0100, 32'h8000_0000, 32'h0002_0100, 32'h7fff_ffff, 0);
    send_segment(32'h0002_0200, 32'h8000_0000, 32'h0002_0200, 32'h7fff_ffff, 0);
    send_segment(32'h8000_0000, 32'h0002_0100, 32'h7fff_ffff, 32'h0002_0100, 0);
    send_segment(32'd0, 32'd0, 32'd128, 32'd0, 0);
    send_segment(32'd0, 32'd0, 32'd0, 32'd200, 0);
    send_segment(32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0, 0);
    send_segment(32'h0005_0000, 32'h0005_0000, 32'h0006_0000, 32'h0001_0000, 0);
    start <= 1'b0;

    // Sender waits for every owed word before going on.
    drain();
    random_phase(150);

    // Zero screen size and an inverted, empty view.
    set_view(32'h0001_0000, 32'hffff_0000, 32'd5, 32'd5, 16'd0, 16'd0);
    send_segment(32'd5, 32'd5, 32'd5, 32'd5, 0);
    send_segment(32'h0001_0000, 32'd0, 32'h0001_0000, 32'd9, 0);
    random_phase(120);

    // Widest view with the largest screen.
    set_view(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             16'hffff, 16'hffff);
    random_phase(150);

    // Small view, screen one pixel wide and three pixels high.
    set_view(32'hffff_f000, 32'h0000_1000, 32'hffff_0000, 32'h0000_8000,
             16'd1, 16'd3);
    random_phase(150);

    // Random settings.
    for (int k = 0; k < 3; k++) begin
      set_view($urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
      random_phase(80);
    end

    drain();
    $display("Covered %0d segments over seven view settings, %0d flag pairs checked.",
             accepted, sb.checked);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
